// File: rtl/two_queue_priority_scheduler_defines.svh
// Assertion macros for the two-queue priority scheduler.
// Included by the top level only; depends on nothing else.
`ifndef TWO_QUEUE_PRIORITY_SCHEDULER_DEFINES_SVH
`define TWO_QUEUE_PRIORITY_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TQPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold starting in the cycle after the antecedent.
`define TQPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tqps_pkg.sv
// Shared types and constants of the two-queue priority scheduler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tqps_pkg;

   localparam int unsigned QueueDepthDefault = 16;
   localparam int unsigned IdWidth           = 16;
   localparam int unsigned TimeWidth         = 16;
   localparam int unsigned CountWidth        = 5;
   localparam int unsigned LimitWidth        = 5;
   localparam int unsigned FuncWidth         = 2;
   localparam int unsigned OutcomeWidth      = 3;

   localparam logic [LimitWidth-1:0] LimitReset = 5'd16;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_HIGH_REQ = 2'd0,
      FUNC_LOW_REQ  = 2'd1,
      FUNC_SERVICE  = 2'd2
   } func_type;

   typedef enum logic [OutcomeWidth-1:0] {
      OUT_ACCEPTED    = 3'd0,
      OUT_REJECTED    = 3'd1,
      OUT_IDLE        = 3'd2,
      OUT_SERVED_HIGH = 3'd3,
      OUT_SERVED_LOW  = 3'd4
   } outcome_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      func_type func;
      logic     high_room;
      logic     low_room;
      logic     high_nonempty;
      logic     low_nonempty;
   } status_type;

   typedef struct packed {
      logic        capture;
      logic        push_high;
      logic        push_low;
      logic        pop_high;
      logic        pop_low;
      logic        respond;
      outcome_type outcome;
   } command_type;

endpackage

// File: rtl/tqps_queue.sv
// One bounded FIFO of (id, arrival stamp) entries with a registered head read.
// Depends on tqps_pkg.
`timescale 1ns / 1ps

module tqps_queue #(
   parameter int unsigned QueueDepth = tqps_pkg::QueueDepthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic                             pop,
   input  logic [tqps_pkg::IdWidth-1:0]     push_id,
   input  logic [tqps_pkg::TimeWidth-1:0]   push_stamp,
   input  logic [tqps_pkg::LimitWidth-1:0]  limit,
   output logic [tqps_pkg::IdWidth-1:0]     head_id,
   output logic [tqps_pkg::TimeWidth-1:0]   head_stamp,
   output logic [tqps_pkg::CountWidth-1:0]  count_next,
   output logic                             has_room,
   output logic                             nonempty
);

   localparam int unsigned IndexWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntW       = tqps_pkg::CountWidth;
   localparam int unsigned LimW       = tqps_pkg::LimitWidth;
   localparam int unsigned EntryWidth = tqps_pkg::IdWidth + tqps_pkg::TimeWidth;
   localparam int unsigned CapValue   = (QueueDepth < 31) ? QueueDepth : 31;
   localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(QueueDepth - 1);
   localparam logic [LimW-1:0]       LimitCap  = LimW'(CapValue);

   logic [EntryWidth-1:0] entries_ff [QueueDepth];
   logic [EntryWidth-1:0] head_entry_ff;
   logic [IndexWidth-1:0] head_ff, head_in;
   logic [IndexWidth-1:0] tail_ff, tail_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic [LimW-1:0]       eff_limit;

   // The head is read every cycle into a register, so the entry is ready in the
   // cycle after the head pointer settles.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= {push_id, push_stamp};
      end
      head_entry_ff <= entries_ff[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == LastIndex) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         head_in  = (head_ff == LastIndex) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   assign eff_limit  = (limit > LimitCap) ? LimitCap : limit;
   assign has_room   = (count_ff < eff_limit);
   assign nonempty   = (count_ff != '0);
   assign count_next = count_in;
   assign head_id    = head_entry_ff[EntryWidth-1:tqps_pkg::TimeWidth];
   assign head_stamp = head_entry_ff[tqps_pkg::TimeWidth-1:0];

endmodule

// File: rtl/tqps_datapath.sv
// Datapath: captured request, limit register, both queues and result registers.
// Depends on tqps_pkg and tqps_queue.
`timescale 1ns / 1ps

module tqps_datapath #(
   parameter int unsigned QueueDepth = tqps_pkg::QueueDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tqps_pkg::command_type             cmd,
   output tqps_pkg::status_type              status,
   input  logic [tqps_pkg::FuncWidth-1:0]    req_func,
   input  logic [tqps_pkg::IdWidth-1:0]      req_plane_id,
   input  logic [tqps_pkg::TimeWidth-1:0]    req_time_now,
   input  logic                              csr_write_enable,
   input  logic [tqps_pkg::LimitWidth-1:0]   csr_write_data,
   output logic                              rsp_strobe,
   output logic [tqps_pkg::OutcomeWidth-1:0] rsp_outcome,
   output logic [tqps_pkg::IdWidth-1:0]      rsp_served_id,
   output logic [tqps_pkg::TimeWidth-1:0]    rsp_waited,
   output logic [tqps_pkg::CountWidth-1:0]   rsp_high_waiting,
   output logic [tqps_pkg::CountWidth-1:0]   rsp_low_waiting
);

   tqps_pkg::func_type                   func_ff;
   logic [tqps_pkg::IdWidth-1:0]         plane_id_ff;
   logic [tqps_pkg::TimeWidth-1:0]       time_now_ff;
   logic [tqps_pkg::LimitWidth-1:0]      queue_limit_ff;

   logic                                 rsp_strobe_ff;
   tqps_pkg::outcome_type                outcome_ff;
   logic [tqps_pkg::IdWidth-1:0]         served_id_ff, served_id_in;
   logic [tqps_pkg::TimeWidth-1:0]       waited_ff, waited_in;
   logic [tqps_pkg::CountWidth-1:0]      high_waiting_ff, low_waiting_ff;

   logic [tqps_pkg::IdWidth-1:0]         high_id, low_id;
   logic [tqps_pkg::TimeWidth-1:0]       high_stamp, low_stamp;
   logic [tqps_pkg::CountWidth-1:0]      high_count_next, low_count_next;
   logic                                 high_room, low_room;
   logic                                 high_nonempty, low_nonempty;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff     <= tqps_pkg::func_type'(req_func);
         plane_id_ff <= req_plane_id;
         time_now_ff <= req_time_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_limit_ff <= tqps_pkg::LimitReset;
      end else if (csr_write_enable) begin
         queue_limit_ff <= csr_write_data;
      end
   end

   tqps_queue #(
      .QueueDepth (QueueDepth)
   ) u_high_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd.push_high),
      .pop        (cmd.pop_high),
      .push_id    (plane_id_ff),
      .push_stamp (time_now_ff),
      .limit      (queue_limit_ff),
      .head_id    (high_id),
      .head_stamp (high_stamp),
      .count_next (high_count_next),
      .has_room   (high_room),
      .nonempty   (high_nonempty)
   );

   tqps_queue #(
      .QueueDepth (QueueDepth)
   ) u_low_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd.push_low),
      .pop        (cmd.pop_low),
      .push_id    (plane_id_ff),
      .push_stamp (time_now_ff),
      .limit      (queue_limit_ff),
      .head_id    (low_id),
      .head_stamp (low_stamp),
      .count_next (low_count_next),
      .has_room   (low_room),
      .nonempty   (low_nonempty)
   );

   always_comb begin
      status.func          = func_ff;
      status.high_room     = high_room;
      status.low_room      = low_room;
      status.high_nonempty = high_nonempty;
      status.low_nonempty  = low_nonempty;
   end

   // Nothing served means the id and waiting time both report zero.
   always_comb begin
      served_id_in = '0;
      waited_in    = '0;
      priority if (cmd.pop_high) begin
         served_id_in = high_id;
         waited_in    = time_now_ff - high_stamp;
      end else if (cmd.pop_low) begin
         served_id_in = low_id;
         waited_in    = time_now_ff - low_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         outcome_ff      <= cmd.outcome;
         served_id_ff    <= served_id_in;
         waited_ff       <= waited_in;
         high_waiting_ff <= high_count_next;
         low_waiting_ff  <= low_count_next;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_outcome      = outcome_ff;
   assign rsp_served_id    = served_id_ff;
   assign rsp_waited       = waited_ff;
   assign rsp_high_waiting = high_waiting_ff;
   assign rsp_low_waiting  = low_waiting_ff;

endmodule

// File: rtl/tqps_ctrl.sv
// Controller: accepts a transaction, then decides push, pop or idle from status.
// Depends on tqps_pkg.
`timescale 1ns / 1ps

module tqps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tqps_pkg::status_type  status,
   output tqps_pkg::command_type cmd
);

   tqps_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tqps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.outcome = tqps_pkg::OUT_IDLE;
      unique case (state_ff)
         tqps_pkg::ST_IDLE: begin
            cmd.capture = start;
            if (start) begin
               state_in = tqps_pkg::ST_EXEC;
            end
         end
         tqps_pkg::ST_EXEC: begin
            cmd.respond = 1'b1;
            state_in    = tqps_pkg::ST_IDLE;
            unique case (status.func)
               tqps_pkg::FUNC_HIGH_REQ: begin
                  cmd.push_high = status.high_room;
                  cmd.outcome   = status.high_room ? tqps_pkg::OUT_ACCEPTED
                                                   : tqps_pkg::OUT_REJECTED;
               end
               tqps_pkg::FUNC_LOW_REQ: begin
                  cmd.push_low = status.low_room;
                  cmd.outcome  = status.low_room ? tqps_pkg::OUT_ACCEPTED
                                                 : tqps_pkg::OUT_REJECTED;
               end
               tqps_pkg::FUNC_SERVICE: begin
                  // Strict priority: the low queue is served only when the
                  // high queue is empty.
                  if (status.high_nonempty) begin
                     cmd.pop_high = 1'b1;
                     cmd.outcome  = tqps_pkg::OUT_SERVED_HIGH;
                  end else if (status.low_nonempty) begin
                     cmd.pop_low = 1'b1;
                     cmd.outcome = tqps_pkg::OUT_SERVED_LOW;
                  end
               end
               default: begin
                  cmd.outcome = tqps_pkg::OUT_IDLE;
               end
            endcase
         end
         default: begin
            state_in = tqps_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff == tqps_pkg::ST_EXEC);

endmodule

// File: rtl/two_queue_priority_scheduler.sv
// Two-queue strict-priority scheduler with a per-queue occupancy limit.
// Users drive start with req_func, req_plane_id and req_time_now; a transaction
// is taken at a clock edge where start is high and busy is low.
// Each transaction produces exactly one result, shown on the rsp_ ports for
// one cycle with rsp_strobe high. The receiver cannot hold results off.
// After the accepting edge the controller enters its execute state, which
// loads the result registers; rsp_strobe is registered from that state.
// No new transaction is taken while busy. The accepting cycle captures the
// request while the head of each queue memory is read into a register; the
// execute state decides, updates the queue pointers, writes the tail entry
// and loads the result registers. busy is high only in the execute state, so
// the next one can be taken in the same cycle the previous result is strobed.
// Users must write the limit register (csr_write_enable, csr_write_data) only
// while no transaction is in flight; the block does not enforce this. The limit
// bounds each queue independently. Reset (synchronous, active high) empties both
// queues, sets the limit to 16 and clears the strobe; queue memory contents are not cleared.
`timescale 1ns / 1ps
`include "two_queue_priority_scheduler_defines.svh"

module two_queue_priority_scheduler #(
   parameter int unsigned QUEUE_DEPTH = tqps_pkg::QueueDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tqps_pkg::FuncWidth-1:0]    req_func,
   input  logic [tqps_pkg::IdWidth-1:0]      req_plane_id,
   input  logic [tqps_pkg::TimeWidth-1:0]    req_time_now,
   input  logic                              csr_write_enable,
   input  logic [tqps_pkg::LimitWidth-1:0]   csr_write_data,
   output logic                              rsp_strobe,
   output logic [tqps_pkg::OutcomeWidth-1:0] rsp_outcome,
   output logic [tqps_pkg::IdWidth-1:0]      rsp_served_id,
   output logic [tqps_pkg::TimeWidth-1:0]    rsp_waited,
   output logic [tqps_pkg::CountWidth-1:0]   rsp_high_waiting,
   output logic [tqps_pkg::CountWidth-1:0]   rsp_low_waiting
);

   tqps_pkg::command_type cmd;
   tqps_pkg::status_type  status;

   tqps_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tqps_datapath #(
      .QueueDepth (QUEUE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_plane_id     (req_plane_id),
      .req_time_now     (req_time_now),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_outcome      (rsp_outcome),
      .rsp_served_id    (rsp_served_id),
      .rsp_waited       (rsp_waited),
      .rsp_high_waiting (rsp_high_waiting),
      .rsp_low_waiting  (rsp_low_waiting)
   );

   `TQPS_ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy, "busy did not follow an accepted transaction")
   `TQPS_ASSERT_NEXT(a_accept_gives_result, clock, reset, start && !busy, ##1 rsp_strobe, "no result two cycles after acceptance")
   `TQPS_ASSERT_SAME(a_strobe_when_free, clock, reset, rsp_strobe, !busy, "result strobed while still busy")
   `TQPS_ASSERT_SAME(a_unserved_zero, clock, reset, rsp_strobe && (rsp_outcome == tqps_pkg::OUT_ACCEPTED || rsp_outcome == tqps_pkg::OUT_REJECTED || rsp_outcome == tqps_pkg::OUT_IDLE), rsp_served_id == '0 && rsp_waited == '0, "unserved result carries an id or waiting time")

endmodule
